// ===== sv/wbp_pkg.sv =====
// Shared types, constants and coding helpers for the word-to-byte mode packer.
// No dependencies; imported by every module of the block.
package wbp_pkg;

  localparam int Q_DEPTH = 4;
  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h00;

  localparam logic [1:0] PRE_NONE  = 2'd0;
  localparam logic [1:0] PRE_LEAVE = 2'd1;
  localparam logic [1:0] PRE_ENTER = 2'd2;

  typedef struct packed {
    logic [15:0] word_in;
    logic        block_end;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              item_last;
    logic              block_last;
  } out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [1:0]        pre;
    logic              send_hi;
    logic              item_last;
    logic              block_last;
  } job_t;

  function automatic logic hi_zero(input logic [15:0] w);
    return w[15:8] == 8'h00;
  endfunction

  function automatic logic mode_next(input logic [15:0] w, input logic ok, input logic bm);
    return hi_zero(w) && (bm || ok);
  endfunction

  function automatic job_t code_job(input logic [15:0] w, input logic ok, input logic bm,
                                    input logic il, input logic bl);
    job_t j;
    j.lo = w[7:0];
    j.hi = w[15:8];
    if (!bm && hi_zero(w) && ok) begin
      j.pre = PRE_ENTER;
    end else if (bm && !hi_zero(w)) begin
      j.pre = PRE_LEAVE;
    end else begin
      j.pre = PRE_NONE;
    end
    j.send_hi = !mode_next(w, ok, bm);
    j.item_last = il;
    j.block_last = bl;
    return j;
  endfunction

endpackage

// ===== sv/wbp_fifo.sv =====
// Short job queue between the front and back parts of the packer.
// Depends on wbp_pkg for the job type.
module wbp_fifo import wbp_pkg::*; #(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = count == CW'(DEPTH);
  assign empty = count == '0;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== sv/wbp_front.sv =====
// Front part: accepts words, keeps the lookahead window and byte mode, issues jobs.
// Depends on wbp_pkg for item and job types and the coding helpers.
module wbp_front import wbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_ready,
  input  in_t  src_data,
  output logic push,
  output job_t push_job,
  input  logic full
);

  logic        byte_mode, byte_mode_next;
  logic [1:0]  cnt, cnt_next;
  logic        flushing, flushing_next;
  logic [1:0]  left, left_next;
  logic [15:0] w0, w0_next, w1, w1_next;
  logic [15:0] win0, win0_next, win1, win1_next, win2, win2_next;
  logic        accept;
  logic        ok_run;
  logic        ok_flush;
  logic        last_flush;

  assign src_ready = !flushing && !full;
  assign accept = src_valid && src_ready;
  assign ok_run = hi_zero(w1) && hi_zero(src_data.word_in);
  assign ok_flush = (left == 2'd3) && hi_zero(win1) && hi_zero(win2);
  assign last_flush = left == 2'd1;

  always_comb begin
    byte_mode_next = byte_mode;
    cnt_next = cnt;
    flushing_next = flushing;
    left_next = left;
    w0_next = w0;
    w1_next = w1;
    win0_next = win0;
    win1_next = win1;
    win2_next = win2;
    push = 1'b0;
    push_job = code_job(w0, ok_run, byte_mode, 1'b1, 1'b0);
    if (flushing) begin
      push_job = code_job(win0, ok_flush, byte_mode, last_flush, last_flush);
      if (!full) begin
        push = 1'b1;
        win0_next = win1;
        win1_next = win2;
        left_next = left - 1'b1;
        if (last_flush) begin
          flushing_next = 1'b0;
          byte_mode_next = 1'b0;
        end else begin
          byte_mode_next = mode_next(win0, ok_flush, byte_mode);
        end
      end
    end else if (accept) begin
      if (!src_data.block_end) begin
        if (cnt == 2'd0) begin
          w0_next = src_data.word_in;
          cnt_next = 2'd1;
        end else if (cnt == 2'd1) begin
          w1_next = src_data.word_in;
          cnt_next = 2'd2;
        end else begin
          push = 1'b1;
          byte_mode_next = mode_next(w0, ok_run, byte_mode);
          w0_next = w1;
          w1_next = src_data.word_in;
        end
      end else begin
        flushing_next = 1'b1;
        cnt_next = 2'd0;
        if (cnt == 2'd0) begin
          win0_next = src_data.word_in;
          left_next = 2'd1;
        end else if (cnt == 2'd1) begin
          win0_next = w0;
          win1_next = src_data.word_in;
          left_next = 2'd2;
        end else begin
          win0_next = w0;
          win1_next = w1;
          win2_next = src_data.word_in;
          left_next = 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mode <= 1'b0;
      cnt <= 2'd0;
      flushing <= 1'b0;
      left <= 2'd0;
    end else begin
      byte_mode <= byte_mode_next;
      cnt <= cnt_next;
      flushing <= flushing_next;
      left <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    w0 <= w0_next;
    w1 <= w1_next;
    win0 <= win0_next;
    win1 <= win1_next;
    win2 <= win2_next;
  end

endmodule

// ===== sv/wbp_back.sv =====
// Back part: takes jobs from the queue and sends their bytes one per cycle while dst is ready.
// Depends on wbp_pkg for job and result types.
module wbp_back import wbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t head,
  input  logic empty,
  output logic pop,
  output logic dst_valid,
  input  logic dst_ready,
  output out_t dst_data
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] phase;
  logic       last_byte;
  logic       take;
  logic       load;

  assign last_byte = phase == (cur.pre + {1'b0, cur.send_hi});
  assign dst_valid = cur_valid;
  assign take = dst_valid && dst_ready;
  assign load = !cur_valid || (take && last_byte);
  assign pop = load && !empty;

  always_comb begin
    if (phase < cur.pre) begin
      dst_data.byte_out = MARK_BYTE;
    end else if (phase == cur.pre) begin
      dst_data.byte_out = cur.lo;
    end else begin
      dst_data.byte_out = cur.hi;
    end
    dst_data.item_last = last_byte && cur.item_last;
    dst_data.block_last = last_byte && cur.block_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase <= 2'd0;
    end else if (load) begin
      cur_valid <= !empty;
      phase <= 2'd0;
    end else if (take) begin
      phase <= phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// ===== sv/word_to_byte_mode_packer.sv =====
// A word's job passes through the job queue, then the back part's job register, whose
// bytes drive dst; a block-end word first sets the front part's flush state.
// Throughput: one byte per cycle while dst is ready; a word gives one to three bytes.
// A block-end word holds src_ready low until the window has drained into the queue.
// Reset (rst, synchronous): word mode, empty window, empty queue, no byte pending.
// Top level: front part, job queue, back part; depends on wbp_pkg.
module word_to_byte_mode_packer import wbp_pkg::*; #(
  parameter int QDEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_ready,
  input  in_t  src_data,
  output logic dst_valid,
  input  logic dst_ready,
  output out_t dst_data
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t push_job;
  job_t head;

  wbp_front u_front (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_data(src_data),
    .push(push), .push_job(push_job), .full(full)
  );

  wbp_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .wr_job(push_job), .full(full),
    .pop(pop), .rd_job(head), .empty(empty)
  );

  wbp_back u_back (
    .clk(clk), .rst(rst),
    .head(head), .empty(empty), .pop(pop),
    .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_data(dst_data)
  );

endmodule

// ===== sv/wbp_checker.sv =====
// Port-level checks for the word-to-byte mode packer, bound to the top level.
// Depends on wbp_pkg for item and result types.
module wbp_checker import wbp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic src_valid,
  input logic src_ready,
  input in_t  src_data,
  input logic dst_valid,
  input logic dst_ready,
  input out_t dst_data
);

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
    else $error("dst item dropped or changed while stalled");

  a_block_item: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.block_last |-> dst_data.item_last)
    else $error("block_last without item_last");

  a_flush_stall: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_ready && src_data.block_end |=> !src_ready)
    else $error("src taken during window flush");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("dst valid right after reset");

endmodule

bind word_to_byte_mode_packer wbp_checker u_chk (.*);

// ===== tb/word_to_byte_mode_packer_tb.sv =====
// Self-checking testbench for word_to_byte_mode_packer: directed and random word blocks in, byte stream out.
// Predicts each block's byte coding locally and checks every byte; depends on wbp_pkg.
`timescale 1ns / 1ps
module word_to_byte_mode_packer_tb;
  import wbp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  in_t  src_data = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  out_t dst_data;

  in_t  pending[$];
  out_t exp_bytes[$];
  out_t burst[$];

  logic        byte_mode_on;
  logic [15:0] held_words[2];
  int          held_n;

  logic src_took = 1'b0;
  int   items_in = 0;
  int   stall_cycles = 0;
  int   hold_left = 0;
  bit   held_off = 1'b0;
  bit   failed = 1'b0;
  bit   quiet;

  assign quiet = items_in >= 120 && items_in < 200;

  word_to_byte_mode_packer dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_data(src_data),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_data(dst_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void put_byte(input logic [7:0] b);
    out_t o;
    o.byte_out = b;
    o.item_last = 1'b0;
    o.block_last = 1'b0;
    burst.push_back(o);
  endfunction

  function automatic void code_word(input logic [15:0] w, input bit run_ok);
    if (!byte_mode_on && w[15:8] == 8'h00) begin
      if (run_ok) begin
        byte_mode_on = 1'b1;
        put_byte(MARK_BYTE);
        put_byte(MARK_BYTE);
      end
    end else if (byte_mode_on && w[15:8] != 8'h00) begin
      byte_mode_on = 1'b0;
      put_byte(MARK_BYTE);
    end
    put_byte(w[7:0]);
    if (!byte_mode_on) begin
      put_byte(w[15:8]);
    end
  endfunction

  function automatic void pack_word(input in_t it);
    logic [15:0] win[3];
    int m;
    bit ok;
    burst.delete();
    if (!it.block_end) begin
      if (held_n < 2) begin
        held_words[held_n] = it.word_in;
        held_n++;
        return;
      end
      ok = held_words[1][15:8] == 8'h00 && it.word_in[15:8] == 8'h00;
      code_word(held_words[0], ok);
      held_words[0] = held_words[1];
      held_words[1] = it.word_in;
    end else begin
      m = 0;
      for (int k = 0; k < held_n; k++) begin
        win[m] = held_words[k];
        m++;
      end
      win[m] = it.word_in;
      m++;
      for (int k = 0; k < m; k++) begin
        ok = (k + 2 < m) && win[k+1][15:8] == 8'h00 && win[k+2][15:8] == 8'h00;
        code_word(win[k], ok);
      end
      byte_mode_on = 1'b0;
      held_n = 0;
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].item_last = 1'b1;
      burst[burst.size()-1].block_last = it.block_end;
    end
    foreach (burst[i]) exp_bytes.push_back(burst[i]);
  endfunction

  task automatic add_word(input logic [15:0] w, input logic last);
    in_t it;
    it.word_in = w;
    it.block_end = last;
    pending.push_back(it);
  endtask

  function automatic logic [15:0] rand_word(input int zero_bias);
    int r;
    r = $urandom_range(99);
    if (r < zero_bias) begin
      return {8'h00, 8'($urandom_range(255))};
    end else if (r < zero_bias + 8) begin
      return 16'h0000;
    end
    return 16'($urandom_range(65535));
  endfunction

  // drive source items
  always @(negedge clk) begin : drive
    bit go;
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || src_took) begin
      go = pending.size() > 0 && (quiet || $urandom_range(99) >= 20);
      if (go) begin
        src_data <= pending.pop_front();
      end
      src_valid <= go;
    end
  end

  // drive sink ready, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      dst_ready <= 1'b0;
    end else if (hold_left > 0) begin
      dst_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_off && items_in >= 60) begin
      held_off <= 1'b1;
      hold_left <= HOLD_CYCLES;
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= quiet || $urandom_range(99) >= 20;
    end
  end

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      src_took <= 1'b0;
      stall_cycles <= 0;
      byte_mode_on = 1'b0;
      held_n = 0;
    end else begin
      src_took <= src_valid && src_ready;
      if (src_valid && src_ready) begin
        pack_word(src_data);
        items_in <= items_in + 1;
      end
      if (dst_valid && dst_ready) begin
        if (exp_bytes.size() == 0) begin
          $error("unexpected byte_out %0h", dst_data.byte_out);
          failed = 1'b1;
        end else begin
          want = exp_bytes.pop_front();
          if (dst_data.byte_out !== want.byte_out) begin
            $error("byte_out: expected %0h, got %0h", want.byte_out, dst_data.byte_out);
            failed = 1'b1;
          end
          if (dst_data.item_last !== want.item_last) begin
            $error("item_last: expected %0b, got %0b", want.item_last, dst_data.item_last);
            failed = 1'b1;
          end
          if (dst_data.block_last !== want.block_last) begin
            $error("block_last: expected %0b, got %0b", want.block_last, dst_data.block_last);
            failed = 1'b1;
          end
        end
      end
      if ((src_valid && src_ready) || (dst_valid && dst_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("word_to_byte_mode_packer regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int len;
    int bias;
    // single-word blocks at the extremes
    add_word(16'h0000, 1'b1);
    add_word(16'hffff, 1'b1);
    // enter byte mode, zero word inside it, leave, flush with full window
    add_word(16'h00ff, 1'b0);
    add_word(16'h0001, 1'b0);
    add_word(16'h0080, 1'b0);
    add_word(16'h0000, 1'b0);
    add_word(16'hff00, 1'b0);
    add_word(16'h8001, 1'b0);
    add_word(16'h0010, 1'b0);
    add_word(16'h0020, 1'b0);
    add_word(16'h0030, 1'b1);
    // flush with one held word: run too short
    add_word(16'h0040, 1'b0);
    add_word(16'h0050, 1'b1);
    // run entered before the flush and carried through it
    add_word(16'h0001, 1'b0);
    add_word(16'h0002, 1'b0);
    add_word(16'h0003, 1'b0);
    add_word(16'h0004, 1'b1);
    add_word(16'h7fff, 1'b0);
    add_word(16'h0000, 1'b1);
    // leave byte mode on the block-end word
    add_word(16'h0011, 1'b0);
    add_word(16'h0022, 1'b0);
    add_word(16'h0033, 1'b0);
    add_word(16'hffff, 1'b1);
    while (pending.size() < 300) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      bias = $urandom_range(20, 80);
      for (int i = 0; i < len; i++) begin
        add_word(rand_word(bias), i == len - 1);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || src_valid || exp_bytes.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed && exp_bytes.size() == 0) begin
      $display("word_to_byte_mode_packer regression: pass");
    end else begin
      $display("word_to_byte_mode_packer regression: fail");
    end
    $finish;
  end

endmodule
